### rtl/rcpp_pkg.sv
// ----------------------------------------------------------------------------
// rcpp_pkg
// Shared types and constants of the control payload packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpp_pkg;

    localparam int CH_W         = 16;
    localparam int SW_W         = 5;
    localparam int BYTE_W       = 8;
    localparam int WIDE_W       = 10;
    localparam int MAG_W        = 14;
    localparam int PROD_W       = 24;
    localparam int QUOT_W       = 9;
    localparam int RECIP_W      = 25;
    localparam int FULL_W       = PROD_W + RECIP_W;
    localparam int DIV_SHIFT    = 39;
    localparam int HOP_W        = 4;
    localparam int HOP_CHANNELS = 15;
    localparam int NUM_WIDE     = 4;
    localparam int NUM_NARROW   = 4;
    localparam int FMT_W        = 3;

    localparam logic signed [CH_W-1:0] CLAMP_HI = 16'sd10000;
    localparam logic signed [CH_W-1:0] CLAMP_LO = -16'sd10000;

    // x * K / 20000 done as (x * K) * RECIP >> DIV_SHIFT, exact for x * K < 2**24
    localparam logic [WIDE_W-1:0]  SCALE_K_WIDE   = 10'd1023;
    localparam logic [WIDE_W-1:0]  SCALE_K_NARROW = 10'd255;
    localparam logic [RECIP_W-1:0] DIV_RECIP      = 25'd27487791;
    localparam logic [WIDE_W-1:0]  MID_WIDE       = 10'd512;
    localparam logic [WIDE_W-1:0]  MID_NARROW     = 10'd128;

    localparam logic [BYTE_W-1:0] CAL_IDLE_MARK = 8'hAA;
    localparam logic [BYTE_W-1:0] CAL_BUSY_MARK = 8'h77;
    localparam logic [BYTE_W-1:0] CAL_PULSE     = 8'h20;
    localparam logic [BYTE_W-1:0] CAL_SATURATE  = 8'd250;
    localparam logic [BYTE_W-1:0] CAL_WIN_LO    = 8'd20;
    localparam logic [BYTE_W-1:0] CAL_WIN_HI    = 8'd25;

    localparam logic [HOP_W-1:0] HOP_LAST = HOP_W'(HOP_CHANNELS - 1);

    localparam int SW_MODE  = 0;
    localparam int SW_FLIP  = 1;
    localparam int SW_VID   = 2;
    localparam int SW_PIC   = 3;
    localparam int SW_CAL   = 4;

    typedef enum logic [FMT_W-1:0] {
        FMT_V1     = 3'd0,
        FMT_V2     = 3'd1,
        FMT_FLAG_A = 3'd2,
        FMT_FLAG_B = 3'd3,
        FMT_FLAG_M = 3'd4
    } t_format;

    typedef struct packed {
        logic en_mul;
        logic en_div;
    } t_lane_ctrl;

endpackage

`default_nettype wire

### rtl/rcpp_if.sv
// ----------------------------------------------------------------------------
// rcpp_if
// Request and payload channels of the control payload packer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcpp_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [15:0]      aileron;
    logic signed [15:0]      elevator;
    logic signed [15:0]      throttle;
    logic signed [15:0]      rudder;
    logic signed [15:0]      gear;
    logic signed [15:0]      pitch;
    logic signed [15:0]      aux_seven;
    logic signed [15:0]      aux_eight;
    logic [4:0]              switches;

    modport source (
        output valid, aileron, elevator, throttle, rudder, gear, pitch,
               aux_seven, aux_eight, switches,
        input  ready
    );
    modport sink (
        input  valid, aileron, elevator, throttle, rudder, gear, pitch,
               aux_seven, aux_eight, switches,
        output ready
    );
endinterface

interface rcpp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte0;
    logic [7:0] payload_byte1;
    logic [7:0] payload_byte2;
    logic [7:0] payload_byte3;
    logic [7:0] payload_byte4;
    logic [7:0] payload_byte5;
    logic [7:0] payload_byte6;
    logic [7:0] payload_byte7;
    logic [7:0] payload_byte8;
    logic [7:0] payload_byte9;
    logic [7:0] payload_byte10;
    logic [3:0] hop_index;

    modport source (
        output valid, payload_byte0, payload_byte1, payload_byte2, payload_byte3,
               payload_byte4, payload_byte5, payload_byte6, payload_byte7,
               payload_byte8, payload_byte9, payload_byte10, hop_index,
        input  ready
    );
    modport sink (
        input  valid, payload_byte0, payload_byte1, payload_byte2, payload_byte3,
               payload_byte4, payload_byte5, payload_byte6, payload_byte7,
               payload_byte8, payload_byte9, payload_byte10, hop_index,
        output ready
    );
endinterface

`default_nettype wire

### rtl/rcpp_lane.sv
// ----------------------------------------------------------------------------
// rcpp_lane
// One channel lane: clamp, scale by 1023 or 255, divide by 20000 toward
// zero and add the midpoint. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpp_lane (
    input  logic                               i_clk,
    input  rcpp_pkg::t_lane_ctrl               i_ctrl,
    input  logic                               i_wide,
    input  logic signed [rcpp_pkg::CH_W-1:0]   i_value,
    output logic [rcpp_pkg::WIDE_W-1:0]        o_scaled
);
    import rcpp_pkg::*;

    logic signed [CH_W-1:0]  clamped;
    logic [CH_W-1:0]         mag_full;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       n_prod;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_neg;
    logic                    r_wide;
    logic [FULL_W-1:0]       full;
    logic [QUOT_W-1:0]       quot;
    logic [WIDE_W-1:0]       mid;
    logic [WIDE_W-1:0]       n_scaled;
    logic [WIDE_W-1:0]       r_scaled;

    always_comb begin
        if (i_value > CLAMP_HI) begin
            clamped = CLAMP_HI;
        end else if (i_value < CLAMP_LO) begin
            clamped = CLAMP_LO;
        end else begin
            clamped = i_value;
        end
        mag_full = clamped[CH_W-1] ? CH_W'(-clamped) : CH_W'(clamped);
        mag      = mag_full[MAG_W-1:0];
        n_prod   = PROD_W'(mag) * PROD_W'(i_wide ? SCALE_K_WIDE : SCALE_K_NARROW);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            r_prod <= n_prod;
            r_neg  <= clamped[CH_W-1];
            r_wide <= i_wide;
        end
    end

    always_comb begin
        full     = FULL_W'(r_prod) * FULL_W'(DIV_RECIP);
        quot     = full[DIV_SHIFT +: QUOT_W];
        mid      = r_wide ? MID_WIDE : MID_NARROW;
        n_scaled = r_neg ? (mid - WIDE_W'(quot)) : (mid + WIDE_W'(quot));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_div) begin
            r_scaled <= n_scaled;
        end
    end

    assign o_scaled = r_scaled;

endmodule

`default_nettype wire

### rtl/rcpp_merge.sv
// ----------------------------------------------------------------------------
// rcpp_merge
// Assembles the 11-byte payload from the lane results, applies the format
// layout, runs the calibration counter and hop position, and holds the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpp_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rcpp_pkg::FMT_W-1:0]          i_format,
    input  logic [rcpp_pkg::WIDE_W-1:0]         i_wide [rcpp_pkg::NUM_WIDE],
    input  logic [rcpp_pkg::WIDE_W-1:0]         i_narrow [rcpp_pkg::NUM_NARROW],
    input  logic [rcpp_pkg::SW_W-1:0]           i_switches,
    rcpp_out_if.source                          o_out
);
    import rcpp_pkg::*;

    logic              take;
    logic              r_valid;
    logic [BYTE_W-1:0] r_cal_count;
    logic [BYTE_W-1:0] n_cal_count;
    logic [HOP_W-1:0]  r_hop;
    logic [HOP_W-1:0]  n_hop;
    logic [BYTE_W-1:0] r_byte [11];
    logic [BYTE_W-1:0] n_byte [11];
    logic [HOP_W-1:0]  r_hop_index;
    logic              cal_fmt;
    logic              calibrating;

    assign o_ready = !r_valid || o_out.ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_byte[0] = i_wide[0][BYTE_W-1:0];
        n_byte[1] = i_wide[1][BYTE_W-1:0];
        n_byte[2] = i_wide[2][BYTE_W-1:0];
        n_byte[3] = i_wide[3][BYTE_W-1:0];
        n_byte[4] = {i_wide[3][9:8], i_wide[2][9:8], i_wide[1][9:8], i_wide[0][9:8]};
        n_byte[5] = i_narrow[0][BYTE_W-1:0];
        n_byte[6] = i_narrow[1][BYTE_W-1:0];
        n_byte[7] = i_narrow[2][BYTE_W-1:0];
        n_byte[8] = i_narrow[3][BYTE_W-1:0];
        n_byte[9] = CAL_IDLE_MARK;
        n_byte[10] = '0;
        n_cal_count = '0;
        cal_fmt = 1'b0;

        case (i_format)
            FMT_FLAG_B: begin
                n_byte[6] = {2'b00, i_switches[SW_MODE], i_switches[SW_VID],
                             i_switches[SW_FLIP], i_switches[SW_PIC], 2'b00};
                cal_fmt   = 1'b1;
            end
            FMT_FLAG_A: begin
                n_byte[6] = {2'b00, i_switches[SW_MODE], 2'b00, i_switches[SW_FLIP],
                             i_switches[SW_VID], i_switches[SW_PIC]};
                cal_fmt   = 1'b1;
            end
            FMT_FLAG_M: begin
                n_byte[6] = {2'b00, i_switches[SW_MODE], 2'b00, i_switches[SW_FLIP],
                             i_switches[SW_VID], i_switches[SW_PIC]};
            end
            default: begin
            end
        endcase

        calibrating = cal_fmt && i_switches[SW_CAL];
        if (calibrating) begin
            n_byte[9] = CAL_BUSY_MARK;
            if (r_cal_count >= CAL_WIN_LO && r_cal_count <= CAL_WIN_HI) begin
                n_byte[10] = CAL_PULSE;
            end
            n_cal_count = (r_cal_count < CAL_SATURATE) ? r_cal_count + 8'd1 : CAL_SATURATE;
        end

        if (i_format == FMT_V1) begin
            n_byte[7]   = '0;
            n_byte[8]   = '0;
            n_byte[9]   = '0;
            n_byte[10]  = '0;
            n_cal_count = r_cal_count;
        end

        n_hop = (r_hop >= HOP_LAST) ? '0 : r_hop + HOP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_cal_count <= '0;
            r_hop       <= '0;
        end else begin
            if (take) begin
                r_valid     <= 1'b1;
                r_cal_count <= n_cal_count;
                r_hop       <= n_hop;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte      <= n_byte;
            r_hop_index <= r_hop;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.payload_byte0  = r_byte[0];
    assign o_out.payload_byte1  = r_byte[1];
    assign o_out.payload_byte2  = r_byte[2];
    assign o_out.payload_byte3  = r_byte[3];
    assign o_out.payload_byte4  = r_byte[4];
    assign o_out.payload_byte5  = r_byte[5];
    assign o_out.payload_byte6  = r_byte[6];
    assign o_out.payload_byte7  = r_byte[7];
    assign o_out.payload_byte8  = r_byte[8];
    assign o_out.payload_byte9  = r_byte[9];
    assign o_out.payload_byte10 = r_byte[10];
    assign o_out.hop_index      = r_hop_index;

endmodule

`default_nettype wire

### rtl/rc_control_payload_packer_top.sv
// ----------------------------------------------------------------------------
// rc_control_payload_packer_top
// Takes one control request per clock and returns one 11-byte payload with
// its hop index per request. Eight channel lanes (two stages each: clamp and
// constant multiply, then reciprocal divide by 20000) feed a merge stage that
// owns the output register. A payload passes each lane's product and result
// registers, then the merge output register; the sustained rate is one request
// per cycle, limited only by downstream ready. The format register must be
// written only while no request is in flight; codes 5 to 7 behave as V2.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_control_payload_packer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rcpp_pkg::FMT_W-1:0]   i_cfg_data,
    rcpp_in_if.sink                      i_in,
    rcpp_out_if.source                   o_out
);
    import rcpp_pkg::*;

    localparam int NUM_LANES = NUM_WIDE + NUM_NARROW;

    logic [FMT_W-1:0]  r_format;
    logic              r_v1;
    logic              r_v2;
    logic [SW_W-1:0]   r_sw1;
    logic [SW_W-1:0]   r_sw2;
    logic              merge_ready;
    t_lane_ctrl        lane_ctrl;
    logic signed [CH_W-1:0] lane_in  [NUM_LANES];
    logic [WIDE_W-1:0]      lane_out [NUM_LANES];
    logic [WIDE_W-1:0]      wide_val   [NUM_WIDE];
    logic [WIDE_W-1:0]      narrow_val [NUM_NARROW];

    assign lane_ctrl.en_div = !r_v2 || merge_ready;
    assign lane_ctrl.en_mul = !r_v1 || !r_v2 || merge_ready;
    assign i_in.ready       = lane_ctrl.en_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_V1;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_format <= i_cfg_data;
            end
            if (lane_ctrl.en_mul) begin
                r_v1 <= i_in.valid;
            end
            if (lane_ctrl.en_div) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_ctrl.en_mul) begin
            r_sw1 <= i_in.switches;
        end
        if (lane_ctrl.en_div) begin
            r_sw2 <= r_sw1;
        end
    end

    assign lane_in[0] = i_in.aileron;
    assign lane_in[1] = i_in.elevator;
    assign lane_in[2] = i_in.throttle;
    assign lane_in[3] = i_in.rudder;
    assign lane_in[4] = i_in.gear;
    assign lane_in[5] = i_in.pitch;
    assign lane_in[6] = i_in.aux_seven;
    assign lane_in[7] = i_in.aux_eight;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rcpp_lane u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (lane_ctrl),
            .i_wide   (g < NUM_WIDE),
            .i_value  (lane_in[g]),
            .o_scaled (lane_out[g])
        );
    end

    for (genvar g = 0; g < NUM_WIDE; g++) begin : g_wide
        assign wide_val[g] = lane_out[g];
    end
    for (genvar g = 0; g < NUM_NARROW; g++) begin : g_narrow
        assign narrow_val[g] = lane_out[NUM_WIDE + g];
    end

    rcpp_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v2),
        .o_ready    (merge_ready),
        .i_format   (r_format),
        .i_wide     (wide_val),
        .i_narrow   (narrow_val),
        .i_switches (r_sw2),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

### tb/rcpp_checker.sv
// ----------------------------------------------------------------------------
// rcpp_checker
// Watches the request and payload channels of the control payload packer,
// predicts each 11-byte payload and its hop index from the accepted request,
// the format register and its own copy of the calibration and hop state, and
// compares every delivered payload against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rcpp_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rcpp_pkg::FMT_W-1:0] i_cfg_data,
    rcpp_in_if                         req_mon,
    rcpp_out_if                        pay_mon,
    output int                         o_fail_count,
    output int                         o_pending
);
    import rcpp_pkg::*;

    typedef struct packed {
        logic [10:0][BYTE_W-1:0] bytes;
        logic [HOP_W-1:0]        hop;
    } t_payload;

    t_payload              expected_payloads [$];
    logic [FMT_W-1:0]      fmt_reg;
    logic [BYTE_W-1:0]     cal_count;
    logic [HOP_W-1:0]      hop_pos;
    int                    fail_count;

    function automatic int clamp_ch(input logic signed [CH_W-1:0] raw);
        int v;
        v = raw;
        if (v < int'(CLAMP_LO))
            v = int'(CLAMP_LO);
        else if (v > int'(CLAMP_HI))
            v = int'(CLAMP_HI);
        return v;
    endfunction

    function automatic logic [WIDE_W-1:0] to_wide(input logic signed [CH_W-1:0] raw);
        return WIDE_W'(clamp_ch(raw) * 1023 / 20000 + 512);
    endfunction

    function automatic logic [BYTE_W-1:0] to_narrow(input logic signed [CH_W-1:0] raw);
        return BYTE_W'(clamp_ch(raw) * 255 / 20000 + 128);
    endfunction

    // builds the payload for the request on req_mon and advances the state
    function automatic t_payload pack_payload();
        t_payload           p;
        logic [WIDE_W-1:0]  w [NUM_WIDE];
        logic [SW_W-1:0]    sw;
        sw   = req_mon.switches;
        w[0] = to_wide(req_mon.aileron);
        w[1] = to_wide(req_mon.elevator);
        w[2] = to_wide(req_mon.throttle);
        w[3] = to_wide(req_mon.rudder);
        p.bytes = '0;
        for (int i = 0; i < NUM_WIDE; i++)
            p.bytes[i] = w[i][7:0];
        p.bytes[4] = {w[3][9:8], w[2][9:8], w[1][9:8], w[0][9:8]};
        p.bytes[5] = to_narrow(req_mon.gear);
        p.bytes[6] = to_narrow(req_mon.pitch);
        if (fmt_reg != FMT_V1) begin
            if (fmt_reg == FMT_FLAG_B) begin
                p.bytes[6] = {2'b00, sw[SW_MODE], sw[SW_VID], sw[SW_FLIP], sw[SW_PIC], 2'b00};
            end else if (fmt_reg == FMT_FLAG_A || fmt_reg == FMT_FLAG_M) begin
                p.bytes[6] = {2'b00, sw[SW_MODE], 2'b00, sw[SW_FLIP], sw[SW_VID], sw[SW_PIC]};
            end
            p.bytes[7] = to_narrow(req_mon.aux_seven);
            p.bytes[8] = to_narrow(req_mon.aux_eight);
            p.bytes[9] = CAL_IDLE_MARK;
            if ((fmt_reg == FMT_FLAG_A || fmt_reg == FMT_FLAG_B) && sw[SW_CAL]) begin
                p.bytes[9] = CAL_BUSY_MARK;
                if (cal_count >= CAL_WIN_LO && cal_count <= CAL_WIN_HI)
                    p.bytes[10] = CAL_PULSE;
                if (cal_count < CAL_SATURATE)
                    cal_count = cal_count + 1'b1;
            end else begin
                cal_count = '0;
            end
        end
        p.hop   = hop_pos;
        hop_pos = (hop_pos >= HOP_LAST) ? '0 : hop_pos + 1'b1;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_payload got;
        t_payload want;
        if (!i_rst_n) begin
            fmt_reg    = FMT_V1;
            cal_count  = '0;
            hop_pos    = '0;
            fail_count = 0;
            expected_payloads.delete();
        end else begin
            if (i_cfg_we)
                fmt_reg = i_cfg_data;
            if (req_mon.valid && req_mon.ready)
                expected_payloads.push_back(pack_payload());
            if (pay_mon.valid && pay_mon.ready) begin
                got.bytes = {pay_mon.payload_byte10, pay_mon.payload_byte9,
                             pay_mon.payload_byte8, pay_mon.payload_byte7,
                             pay_mon.payload_byte6, pay_mon.payload_byte5,
                             pay_mon.payload_byte4, pay_mon.payload_byte3,
                             pay_mon.payload_byte2, pay_mon.payload_byte1,
                             pay_mon.payload_byte0};
                got.hop = pay_mon.hop_index;
                if (expected_payloads.size() == 0) begin
                    $display("%0t: payload with no request pending, expected none, actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = expected_payloads.pop_front();
                    for (int i = 0; i < 11; i++) begin
                        if (got.bytes[i] !== want.bytes[i]) begin
                            $display("%0t: payload_byte%0d expected %02h actual %02h",
                                     $time, i, want.bytes[i], got.bytes[i]);
                            fail_count++;
                        end
                    end
                    if (got.hop !== want.hop) begin
                        $display("%0t: hop_index expected %0d actual %0d",
                                 $time, want.hop, got.hop);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    = expected_payloads.size();
        o_fail_count = fail_count;
    end

endmodule

### tb/tb_rc_control_payload_packer_top.sv
// ----------------------------------------------------------------------------
// tb_rc_control_payload_packer_top
// Drives control requests into the payload packer under every format code,
// with directed corner requests, long calibration runs and random traffic,
// random idling on both channels, a long output hold-off and drained format
// changes. The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rc_control_payload_packer_top;
    import rcpp_pkg::*;

    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int STUCK_LIMIT     = 1000;
    localparam int NUM_PHASES      = 15;
    localparam int SHORT_PHASE     = 75;
    localparam int LONG_PHASE      = 300;
    localparam int CAL_RUN         = 260;

    localparam logic [FMT_W-1:0] FMT_SPARE_LO  = 3'd5;
    localparam logic [FMT_W-1:0] FMT_SPARE_MID = 3'd6;
    localparam logic [FMT_W-1:0] FMT_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic signed [CH_W-1:0] aileron;
        logic signed [CH_W-1:0] elevator;
        logic signed [CH_W-1:0] throttle;
        logic signed [CH_W-1:0] rudder;
        logic signed [CH_W-1:0] gear;
        logic signed [CH_W-1:0] pitch;
        logic signed [CH_W-1:0] aux_seven;
        logic signed [CH_W-1:0] aux_eight;
        logic [SW_W-1:0]        switches;
    } t_ctl_request;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [FMT_W-1:0]   cfg_data;
    int                 fail_count;
    int                 pending;
    int                 stuck_cycles = 0;
    int                 stall_requests = 0;
    int                 stalls_done = 0;
    int                 hold_left = 0;
    bit                 no_idle = 1'b0;

    logic signed [CH_W-1:0] corner_vals [6] = '{16'sh8000, 16'sh7FFF, -16'sd10000,
                                                16'sd10000, -16'sd10001, 16'sd10001};
    logic [FMT_W-1:0] plan_fmt [NUM_PHASES] = '{FMT_V2, FMT_FLAG_A, FMT_V1, FMT_FLAG_B,
                                                FMT_FLAG_M, FMT_SPARE_LO, FMT_FLAG_B,
                                                FMT_SPARE_MID, FMT_SPARE_HI, FMT_FLAG_A,
                                                FMT_V1, FMT_FLAG_B, FMT_FLAG_M, FMT_FLAG_A,
                                                FMT_V2};

    rcpp_in_if  req_ch ();
    rcpp_out_if pay_ch ();

    rc_control_payload_packer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (req_ch),
        .o_out      (pay_ch)
    );

    rcpp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .req_mon      (req_ch),
        .pay_mon      (pay_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 7))
            0, 1:    return CH_W'($urandom);
            2, 3, 4: return CH_W'(int'($urandom_range(0, 20000)) - 10000);
            5:       return corner_vals[$urandom_range(0, 5)];
            default: return CH_W'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic t_ctl_request rand_request(input logic cal);
        t_ctl_request r;
        r.aileron   = rand_channel();
        r.elevator  = rand_channel();
        r.throttle  = rand_channel();
        r.rudder    = rand_channel();
        r.gear      = rand_channel();
        r.pitch     = rand_channel();
        r.aux_seven = rand_channel();
        r.aux_eight = rand_channel();
        r.switches  = {cal, 4'($urandom)};
        return r;
    endfunction

    function automatic t_ctl_request flat_request(input logic signed [CH_W-1:0] v,
                                                  input logic [SW_W-1:0] sw);
        return '{v, v, v, v, v, v, v, v, sw};
    endfunction

    // returns at the rising edge where the request is taken
    task automatic send_request(input t_ctl_request r);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 30) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.aileron   <= r.aileron;
        req_ch.elevator  <= r.elevator;
        req_ch.throttle  <= r.throttle;
        req_ch.rudder    <= r.rudder;
        req_ch.gear      <= r.gear;
        req_ch.pitch     <= r.pitch;
        req_ch.aux_seven <= r.aux_seven;
        req_ch.aux_eight <= r.aux_eight;
        req_ch.switches  <= r.switches;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_pipe();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_format(input logic [FMT_W-1:0] fmt);
        drain_pipe();
        cfg_we   <= 1'b1;
        cfg_data <= fmt;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (pay_ch.valid && pay_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // payload side: random ready, long hold-off on demand
    initial begin
        pay_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left == 0 && stall_requests != stalls_done) begin
                hold_left = HOLD_OFF_CYCLES;
                stalls_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                pay_ch.ready <= 1'b0;
            end else begin
                pay_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    initial begin
        t_ctl_request r;
        int           n;
        logic         cal;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = FMT_V1;
        req_ch.valid     = 1'b0;
        req_ch.aileron   = '0;
        req_ch.elevator  = '0;
        req_ch.throttle  = '0;
        req_ch.rudder    = '0;
        req_ch.gear      = '0;
        req_ch.pitch     = '0;
        req_ch.aux_seven = '0;
        req_ch.aux_eight = '0;
        req_ch.switches  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // format left at its reset value
        send_request(flat_request(16'sh7FFF, '1));
        send_request(flat_request(16'sh8000, '0));
        send_request(flat_request(16'sd10000, 5'b10101));
        send_request(flat_request(-16'sd10000, 5'b01010));
        send_request(flat_request(16'sd10001, '1));
        send_request(flat_request(-16'sd10001, '0));
        send_request(flat_request('0, '0));
        r = flat_request(-16'sd1, '0);
        r.elevator  = 16'sd1;
        r.throttle  = 16'sd19;
        r.rudder    = -16'sd20;
        r.gear      = 16'sd78;
        r.pitch     = -16'sd79;
        r.aux_eight = 16'sd1;
        send_request(r);

        write_format(FMT_FLAG_B);
        for (int b = 0; b < SW_W; b++) begin
            r = rand_request(1'b0);
            r.switches = SW_W'(1) << b;
            send_request(r);
        end
        r.switches = '1;
        send_request(r);
        write_format(FMT_FLAG_A);
        for (int b = 0; b < SW_W; b++) begin
            r = rand_request(1'b0);
            r.switches = SW_W'(1) << b;
            send_request(r);
        end
        write_format(FMT_FLAG_M);
        r.switches = '1;
        send_request(r);
        write_format(FMT_V2);
        send_request(r);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_format(plan_fmt[p]);
            no_idle = (p == 5 || p == 6);
            if (p == 4 || p == 10)
                stall_requests++;
            n = (p == 1 || p == 3) ? LONG_PHASE : SHORT_PHASE;
            for (int k = 0; k < n; k++) begin
                if (n == LONG_PHASE)
                    cal = !(k >= CAL_RUN && $urandom_range(0, 3) == 0);
                else
                    cal = ($urandom_range(0, 3) != 0);
                send_request(rand_request(cal));
            end
        end
        no_idle = 1'b0;

        drain_pipe();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/rcpp_pkg.sv
rtl/rcpp_if.sv
rtl/rcpp_lane.sv
rtl/rcpp_merge.sv
rtl/rc_control_payload_packer_top.sv
tb/rcpp_checker.sv
tb/tb_rc_control_payload_packer_top.sv
